FILE: hdl/fpcr_pkg.sv
package fpcr_pkg;

    localparam int MaxFrame = 120;
    localparam int CountW   = $clog2(MaxFrame);

    localparam logic [7:0] ChOpen  = 8'h3C;
    localparam logic [7:0] ChClose = 8'h3E;
    localparam logic [7:0] ChBar   = 8'h7C;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChOne   = 8'h31;
    localparam logic [7:0] ChSeven = 8'h37;

    localparam int TailDigitsMax = 3;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_STORED  = 3'd1,
        ST_GOOD    = 3'd2,
        ST_BADSUM  = 3'd3,
        ST_ABORT   = 3'd4,
        ST_UNKNOWN = 3'd5
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] data_byte;
        logic [2:0] command;
        logic [6:0] payload_length;
    } t_result;

endpackage

FILE: hdl/framed_packet_checksum_receiver.sv
// Framed packet checksum receiver.
// Input channel: i_valid / o_stall carry one received character per beat on
// i_rx_byte. Output channel: o_valid / i_stall carry one result per input
// beat: o_status, o_data_byte, o_command, o_payload_length.
// A frame runs from '<' to '>'; the text after the last '|' must be the
// modulo-256 sum of the payload up to and including that '|', in decimal.
// Each accepted byte gives exactly one result, in order.
// Each result is registered after the frame state update: in the single result
// register, or in the skid register when the receiver holds the result register.
// One byte per cycle while the skid register is empty; the skid register lets a
// byte be taken in the cycle the receiver first stalls.
// When the receiver stalls, the result register holds, the next result waits
// in the skid register and o_stall rises until the skid register drains.
// Reset (synchronous, active low) returns the parser to outside a frame,
// clears all frame state and empties both result registers.
module framed_packet_checksum_receiver
    import fpcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_status,
    output logic [7:0] o_data_byte,
    output logic [2:0] o_command,
    output logic [6:0] o_payload_length
);

    logic              r_in_frame,  n_in_frame;
    logic [CountW-1:0] r_count,     n_count;
    logic [7:0]        r_sum,       n_sum;
    logic [7:0]        r_bar_sum,   n_bar_sum;
    logic              r_bar_seen,  n_bar_seen;
    logic [9:0]        r_tail_val,  n_tail_val;
    logic [2:0]        r_tail_dig,  n_tail_dig;
    logic              r_tail_bad,  n_tail_bad;
    logic [7:0]        r_first,     n_first;

    t_result r_out, r_skid, res;
    logic    r_out_valid, r_skid_valid;

    logic       accept, out_take;
    logic [7:0] b;
    logic       is_digit, sum_ok, cmd_ok, too_long;
    logic [CountW:0] count_inc;

    assign accept   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign b        = i_rx_byte;

    assign is_digit  = (b >= ChZero) && (b <= ChNine);
    assign count_inc = (CountW+1)'(r_count) + 1'b1;
    assign too_long  = count_inc >= (CountW+1)'(MaxFrame);
    assign sum_ok    = r_bar_seen && !r_tail_bad && (r_tail_dig != 3'd0)
                       && (r_tail_val == {2'b00, r_bar_sum});
    assign cmd_ok    = (r_first >= ChOne) && (r_first <= ChSeven);

    always_comb begin
        n_in_frame = r_in_frame;
        n_count    = r_count;
        n_sum      = r_sum;
        n_bar_sum  = r_bar_sum;
        n_bar_seen = r_bar_seen;
        n_tail_val = r_tail_val;
        n_tail_dig = r_tail_dig;
        n_tail_bad = r_tail_bad;
        n_first    = r_first;

        res.status         = ST_IDLE;
        res.data_byte      = 8'd0;
        res.command        = 3'd0;
        res.payload_length = 7'd0;

        if (!r_in_frame) begin
            if (b == ChOpen) begin
                n_in_frame = 1'b1;
                n_count    = '0;
                n_sum      = 8'd0;
                n_bar_sum  = 8'd0;
                n_bar_seen = 1'b0;
                n_tail_val = 10'd0;
                n_tail_dig = 3'd0;
                n_tail_bad = 1'b0;
                n_first    = 8'd0;
            end
        end else if (b == ChOpen) begin
            n_in_frame         = 1'b0;
            res.status         = ST_ABORT;
            res.payload_length = 7'(r_count);
        end else if (b == ChClose) begin
            n_in_frame         = 1'b0;
            res.payload_length = 7'(r_count);
            if (!sum_ok) begin
                res.status = ST_BADSUM;
            end else if (cmd_ok) begin
                res.status  = ST_GOOD;
                res.command = r_first[2:0];
            end else begin
                res.status = ST_UNKNOWN;
            end
        end else if (too_long) begin
            n_in_frame         = 1'b0;
            res.status         = ST_ABORT;
            res.payload_length = 7'(r_count);
        end else begin
            if (r_count == '0) begin
                n_first = b;
            end
            n_count = count_inc[CountW-1:0];
            n_sum   = r_sum + b;
            if (b == ChBar) begin
                n_bar_sum  = r_sum + b;
                n_bar_seen = 1'b1;
                n_tail_val = 10'd0;
                n_tail_dig = 3'd0;
                n_tail_bad = 1'b0;
            end else if (!is_digit || r_tail_dig >= 3'(TailDigitsMax)) begin
                n_tail_bad = 1'b1;
            end else begin
                // no leading zeros: a digit after a lone zero spoils the tail
                if (r_tail_dig != 3'd0 && r_tail_val == 10'd0) begin
                    n_tail_bad = 1'b1;
                end
                n_tail_val = {r_tail_val[6:0], 3'b000} + {r_tail_val[8:0], 1'b0}
                             + {6'd0, b[3:0]};
                n_tail_dig = r_tail_dig + 3'd1;
            end
            res.status    = ST_STORED;
            res.data_byte = b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_count    <= '0;
            r_sum      <= 8'd0;
            r_bar_sum  <= 8'd0;
            r_bar_seen <= 1'b0;
            r_tail_val <= 10'd0;
            r_tail_dig <= 3'd0;
            r_tail_bad <= 1'b0;
            r_first    <= 8'd0;
        end else if (accept) begin
            r_in_frame <= n_in_frame;
            r_count    <= n_count;
            r_sum      <= n_sum;
            r_bar_sum  <= n_bar_sum;
            r_bar_seen <= n_bar_seen;
            r_tail_val <= n_tail_val;
            r_tail_dig <= n_tail_dig;
            r_tail_bad <= n_tail_bad;
            r_first    <= n_first;
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !out_take) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (accept) begin
            if (r_out_valid && !out_take) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_stall          = r_skid_valid;
    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_data_byte      = r_out.data_byte;
    assign o_command        = r_out.command;
    assign o_payload_length = r_out.payload_length;

endmodule

FILE: hdl/fpcr_checker.sv
module fpcr_checker
    import fpcr_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_status,
    input logic [7:0] o_data_byte,
    input logic [2:0] o_command,
    input logic [6:0] o_payload_length
);

    // a beat taken on the input always leaves a result valid on the output in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted beat gave no result");

    // command only on a good frame, and then a real command digit
    a_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == ST_GOOD) ? (o_command != 3'd0) : (o_command == 3'd0)))
        else $error("command field inconsistent with status");

    // length only on frame-ending results, data only on stored bytes; checked on idle and stored results
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_IDLE || o_status == ST_STORED))
            |-> (o_payload_length == 7'd0
                 && (o_status == ST_STORED || o_data_byte == 8'd0)))
        else $error("stray field on idle or stored result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)
                                  && $stable(o_data_byte)))
        else $error("stalled result changed");

endmodule

bind framed_packet_checksum_receiver fpcr_checker u_fpcr_checker (.*);

FILE: verif/tb_framed_packet_checksum_receiver.sv
`timescale 1ns / 100ps

module tb_framed_packet_checksum_receiver;
    import fpcr_pkg::*;

    localparam int DirectedRows  = 26;
    localparam int RandomItems   = 800;
    localparam int HoldCycles    = 150;
    localparam int DrainTail     = 8;
    localparam int WatchdogLimit = 2000;

    typedef enum int {
        FrameNoise,
        FrameOverlong,
        FrameNested,
        FrameNormal
    } t_frame_form;

    typedef enum int {
        TailExact      = 0,
        TailWrong      = 1,
        TailLeadZero   = 2,
        TailExtraDigit = 3,
        TailJunk       = 4,
        TailEmpty      = 5
    } t_tail_form;

    typedef struct packed {
        logic [7:0] rx;
        logic       pinned;
        t_result    want;
    } t_script_row;

    logic       i_clk;
    logic       i_rst_n    = 1'b0;
    logic       i_valid    = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte  = 8'h00;
    logic       o_valid;
    logic       i_stall    = 1'b0;
    logic [2:0] o_status;
    logic [7:0] o_data_byte;
    logic [2:0] o_command;
    logic [6:0] o_payload_length;

    // travels alongside the byte so the monitor knows a hand-written expectation
    logic       drive_pinned = 1'b0;
    t_result    drive_want   = '0;

    // receiver state as the checker sees it
    logic       frame_open = 1'b0;
    int         pay_count  = 0;
    logic [7:0] pay_sum    = '0;
    logic [7:0] bar_sum    = '0;
    logic       bar_found  = 1'b0;
    logic [9:0] tail_val   = '0;
    int         tail_cnt   = 0;
    logic       tail_err   = 1'b0;
    logic [7:0] cmd_byte   = '0;

    t_result     expected_results [$];
    t_script_row script [DirectedRows];
    int          error_count  = 0;
    int          results_seen = 0;
    int          sent_count   = 0;
    int          burst_left   = 0;
    int          quiet_cycles = 0;

    framed_packet_checksum_receiver DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_data_byte      (o_data_byte),
        .o_command        (o_command),
        .o_payload_length (o_payload_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result parse_rx_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        if (!frame_open) begin
            if (b == ChOpen) begin
                frame_open = 1'b1;
                pay_count  = 0;
                pay_sum    = '0;
                bar_sum    = '0;
                bar_found  = 1'b0;
                tail_val   = '0;
                tail_cnt   = 0;
                tail_err   = 1'b0;
                cmd_byte   = '0;
            end
        end else if (b == ChOpen) begin
            frame_open       = 1'b0;
            r.status         = ST_ABORT;
            r.payload_length = 7'(pay_count);
        end else if (b == ChClose) begin
            frame_open       = 1'b0;
            r.payload_length = 7'(pay_count);
            if (!(bar_found && !tail_err && tail_cnt > 0 && tail_val == {2'b00, bar_sum}))
                r.status = ST_BADSUM;
            else if (cmd_byte >= ChOne && cmd_byte <= ChSeven) begin
                r.status  = ST_GOOD;
                r.command = 3'(cmd_byte - ChZero);
            end else
                r.status = ST_UNKNOWN;
        end else if (pay_count + 1 >= MaxFrame) begin
            // the byte that would fill the frame is dropped
            frame_open       = 1'b0;
            r.status         = ST_ABORT;
            r.payload_length = 7'(pay_count);
        end else begin
            if (pay_count == 0)
                cmd_byte = b;
            pay_count++;
            pay_sum = pay_sum + b;
            if (b == ChBar) begin
                bar_sum   = pay_sum;
                bar_found = 1'b1;
                tail_val  = '0;
                tail_cnt  = 0;
                tail_err  = 1'b0;
            end else if (b < ChZero || b > ChNine || tail_cnt >= TailDigitsMax) begin
                tail_err = 1'b1;
            end else begin
                if (tail_cnt >= 1 && tail_val == 0)
                    tail_err = 1'b1;
                tail_val = 10'(tail_val * 10 + (b - ChZero));
                tail_cnt++;
            end
            r.status    = ST_STORED;
            r.data_byte = b;
        end
        return r;
    endfunction

    function automatic t_script_row fixed_row(input logic [7:0] rx, input t_status st,
                                              input logic [7:0] data, input logic [2:0] cmd,
                                              input logic [6:0] len);
        t_script_row row;
        row.rx                  = rx;
        row.pinned              = 1'b1;
        row.want.status         = st;
        row.want.data_byte      = data;
        row.want.command        = cmd;
        row.want.payload_length = len;
        return row;
    endfunction

    function automatic t_script_row predicted_row(input logic [7:0] rx);
        t_script_row row;
        row        = '0;
        row.rx     = rx;
        row.pinned = 1'b0;
        return row;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic pinned, input t_result want);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        i_valid      <= 1'b1;
        i_rx_byte    <= b;
        drive_pinned <= pinned;
        drive_want   <= want;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
        sent_count++;
    endtask

    task automatic drain_results();
        i_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic send_random_frame();
        logic [7:0]  text [$];
        logic [7:0]  sum;
        logic [7:0]  b;
        int          pick;
        int          body_len;
        int          tail_num;
        t_frame_form form;
        t_tail_form  tail;
        pick = $urandom_range(0, 99);
        form = (pick < 6)  ? FrameNoise :
               (pick < 9)  ? FrameOverlong :
               (pick < 15) ? FrameNested : FrameNormal;
        if (form == FrameNoise) begin
            repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            text.push_back(ChOpen);
            body_len = (form == FrameOverlong) ? $urandom_range(MaxFrame - 5, MaxFrame + 2)
                                               : $urandom_range(0, 10);
            sum = '0;
            for (int i = 0; i < body_len; i++) begin
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (b == ChOpen || b == ChClose);
                if (i == 0 && $urandom_range(0, 4) != 0)
                    b = 8'(ChOne + $urandom_range(0, 6));
                text.push_back(b);
                sum = sum + b;
            end
            if (form == FrameNested)
                text.push_back(ChOpen);
            else begin
                if (form == FrameNormal && $urandom_range(0, 19) != 0) begin
                    text.push_back(ChBar);
                    sum  = sum + ChBar;
                    pick = $urandom_range(0, 9);
                    tail = (pick < 5) ? TailExact : t_tail_form'(pick - 4);
                    tail_num = (tail == TailWrong) ? (int'(sum) + $urandom_range(1, 255)) % 256
                                                   : int'(sum);
                    if (tail == TailLeadZero)
                        text.push_back(ChZero);
                    if (tail == TailJunk) begin
                        do begin
                            b = 8'($urandom_range(0, 255));
                        end while (b == ChOpen || b == ChClose);
                        text.push_back(b);
                    end
                    if (tail != TailEmpty) begin
                        if (tail_num >= 100)
                            text.push_back(8'(ChZero + tail_num / 100));
                        if (tail_num >= 10)
                            text.push_back(8'(ChZero + (tail_num / 10) % 10));
                        text.push_back(8'(ChZero + tail_num % 10));
                    end
                    if (tail == TailExtraDigit)
                        text.push_back(8'(ChZero + $urandom_range(0, 9)));
                end
                text.push_back(ChClose);
            end
        end
        foreach (text[i]) send_byte(text[i], 1'b0, '0);
    endtask

    // receiver stalls in phases of varying density, with one long hold-off
    initial begin
        int   phase_left;
        int   stall_pct;
        logic held;
        phase_left = 0;
        stall_pct  = 0;
        held       = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && results_seen >= DirectedRows + 300) begin
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HoldCycles) @(posedge i_clk);
                i_stall <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    phase_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                phase_left--;
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : beat_monitor
        t_result want;
        t_result predicted;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result beat with no byte outstanding: status %0d", o_status);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        error_count++;
                    end
                    if (o_data_byte !== want.data_byte) begin
                        $error("data_byte: expected %0h, got %0h", want.data_byte, o_data_byte);
                        error_count++;
                    end
                    if (o_command !== want.command) begin
                        $error("command: expected %0d, got %0d", want.command, o_command);
                        error_count++;
                    end
                    if (o_payload_length !== want.payload_length) begin
                        $error("payload_length: expected %0d, got %0d",
                               want.payload_length, o_payload_length);
                        error_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                predicted = parse_rx_byte(i_rx_byte);
                expected_results.push_back(drive_pinned ? drive_want : predicted);
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                quiet_cycles = 0;
            else begin
                quiet_cycles++;
                if (quiet_cycles >= WatchdogLimit) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        logic mid_pause_done;
        mid_pause_done = 1'b0;
        script = '{
            // outside a frame only the opener matters, a stray closer included
            fixed_row(ChClose, ST_IDLE,   8'h00,   3'd0, 7'd0),
            fixed_row(8'hFF,   ST_IDLE,   8'h00,   3'd0, 7'd0),
            fixed_row(ChOpen,  ST_IDLE,   8'h00,   3'd0, 7'd0),
            fixed_row(ChOne,   ST_STORED, ChOne,   3'd0, 7'd0),
            fixed_row(ChBar,   ST_STORED, ChBar,   3'd0, 7'd0),
            // 0x31 + 0x7c = 173
            fixed_row(ChOne,   ST_STORED, ChOne,   3'd0, 7'd0),
            fixed_row(ChSeven, ST_STORED, ChSeven, 3'd0, 7'd0),
            fixed_row(8'h33,   ST_STORED, 8'h33,   3'd0, 7'd0),
            predicted_row(ChClose),
            fixed_row(ChOpen,  ST_IDLE,   8'h00,   3'd0, 7'd0),
            fixed_row(ChNine,  ST_STORED, ChNine,  3'd0, 7'd0),
            // nested opener aborts and leaves the parser idle
            fixed_row(ChOpen,  ST_ABORT,  8'h00,   3'd0, 7'd1),
            fixed_row(ChOpen,  ST_IDLE,   8'h00,   3'd0, 7'd0),
            fixed_row(8'h00,   ST_STORED, 8'h00,   3'd0, 7'd0),
            // frame with no separator
            fixed_row(ChClose, ST_BADSUM, 8'h00,   3'd0, 7'd1),
            fixed_row(ChOpen,  ST_IDLE,   8'h00,   3'd0, 7'd0),
            fixed_row(8'h38,   ST_STORED, 8'h38,   3'd0, 7'd0),
            fixed_row(ChBar,   ST_STORED, ChBar,   3'd0, 7'd0),
            // 0x38 + 0x7c = 180, right sum behind a command outside 1..7
            fixed_row(ChOne,   ST_STORED, ChOne,   3'd0, 7'd0),
            fixed_row(8'h38,   ST_STORED, 8'h38,   3'd0, 7'd0),
            fixed_row(ChZero,  ST_STORED, ChZero,  3'd0, 7'd0),
            predicted_row(ChClose),
            fixed_row(ChOpen,  ST_IDLE,   8'h00,   3'd0, 7'd0),
            fixed_row(8'hFF,   ST_STORED, 8'hFF,   3'd0, 7'd0),
            fixed_row(ChBar,   ST_STORED, ChBar,   3'd0, 7'd0),
            // nothing after the separator
            fixed_row(ChClose, ST_BADSUM, 8'h00,   3'd0, 7'd2)
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (script[k]) send_byte(script[k].rx, script[k].pinned, script[k].want);
        drain_results();
        while (sent_count < DirectedRows + RandomItems) begin
            send_random_frame();
            if (!mid_pause_done && sent_count >= DirectedRows + RandomItems / 2) begin
                mid_pause_done = 1'b1;
                drain_results();
            end
        end
        drain_results();
        repeat (DrainTail) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/fpcr_pkg.sv
hdl/framed_packet_checksum_receiver.sv
hdl/fpcr_checker.sv
verif/tb_framed_packet_checksum_receiver.sv
